>>> hdl/c2p3_pkg.sv
// Shared types, constants and arctangent table for the cartesian to polar 3-D unit.
package c2p3_pkg;

  localparam int CORDIC_STAGES = 32;   // micro-rotations per pass, 8..40
  localparam int TABLE_LEN     = 40;
  localparam int SHIFT_W       = 6;    // holds shift amounts 0..TABLE_LEN-1
  localparam int GUARD_BITS    = 16;
  localparam int DATA_W        = 52;   // datapath width, covers 2^47 inputs times CORDIC gain
  localparam int ANGLE_W       = 32;
  localparam int COORD_W       = 32;
  localparam int GAIN_SPLIT    = 24;   // low slice width of the gain multiply

  localparam logic [31:0]        GAIN_INV  = 32'h9B74EDA8;
  localparam logic [ANGLE_W-1:0] ANGLE_PI  = 32'h80000000;
  localparam logic signed [ANGLE_W-1:0] LAT_LIMIT = 32'sd1073741824;

  // atan(2^-i) in units of pi/2^31
  localparam logic [ANGLE_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } point_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] lon_angle;
    logic signed [ANGLE_W-1:0] lat_angle;
    logic        [31:0]        radius;
  } result_t;

  // data that rides along the rotation chain untouched
  typedef struct packed {
    logic                      origin;
    logic signed [COORD_W-1:0] z;
    logic [ANGLE_W-1:0]        lon;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [ANGLE_W-1:0]       angle;
    side_t                    side;
  } cordic_t;

endpackage

>>> hdl/c2p3_cordic_cell.sv
// One registered CORDIC vectoring micro-rotation.
module c2p3_cordic_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [c2p3_pkg::SHIFT_W-1:0] shift_amt,
  input  logic [c2p3_pkg::ANGLE_W-1:0] atan_val,
  input  logic                         src_valid,
  input  c2p3_pkg::cordic_t            src,
  output logic                         dst_valid,
  output c2p3_pkg::cordic_t            dst
);
  import c2p3_pkg::*;

  logic signed [DATA_W-1:0] xi, yi, xs, ys;
  cordic_t dst_next;

  assign xi = src.x;
  assign yi = src.y;
  assign xs = xi >>> shift_amt;
  assign ys = yi >>> shift_amt;

  always_comb begin
    dst_next = src;
    if (yi < 0) begin
      dst_next.x     = xi - ys;
      dst_next.y     = yi + xs;
      dst_next.angle = src.angle - atan_val;
    end else begin
      dst_next.x     = xi + ys;
      dst_next.y     = yi - xs;
      dst_next.angle = src.angle + atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst <= dst_next;
    end
  end

endmodule

>>> hdl/c2p3_cordic_pass.sv
// Chain of CORDIC cells forming one full vectoring pass.
module c2p3_cordic_pass (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              src_valid,
  input  c2p3_pkg::cordic_t src,
  output logic              dst_valid,
  output c2p3_pkg::cordic_t dst
);
  import c2p3_pkg::*;

  logic    valid_chain [CORDIC_STAGES+1];
  cordic_t data_chain  [CORDIC_STAGES+1];

  assign valid_chain[0] = src_valid;
  assign data_chain[0]  = src;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    c2p3_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .shift_amt (SHIFT_W'(i)),
      .atan_val  (ATAN_TAB[i]),
      .src_valid (valid_chain[i]),
      .src       (data_chain[i]),
      .dst_valid (valid_chain[i+1]),
      .dst       (data_chain[i+1])
    );
  end

  assign dst_valid = valid_chain[CORDIC_STAGES];
  assign dst       = data_chain[CORDIC_STAGES];

endmodule

>>> hdl/c2p3_gain_comp.sv
// Two-stage CORDIC gain compensation: x becomes floor(x * GAIN_INV / 2^32).
module c2p3_gain_comp (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              src_valid,
  input  c2p3_pkg::cordic_t src,
  output logic              dst_valid,
  output c2p3_pkg::cordic_t dst
);
  import c2p3_pkg::*;

  localparam int HI_W   = DATA_W - GAIN_SPLIT;
  localparam int A_W    = HI_W + 32;
  localparam int B_W    = GAIN_SPLIT + 32;
  localparam int REST_W = B_W + 1;

  logic [HI_W-1:0]       hi;
  logic [GAIN_SPLIT-1:0] lo;
  logic [A_W-1:0]        a_next, a;
  logic [B_W-1:0]        b_next, b;
  logic [REST_W-1:0]     rest;
  logic                  mid_valid;
  cordic_t               mid, dst_next;

  // x is never negative here
  assign hi     = src.x[DATA_W-1:GAIN_SPLIT];
  assign lo     = src.x[GAIN_SPLIT-1:0];
  assign a_next = A_W'(hi) * A_W'(GAIN_INV);
  assign b_next = B_W'(lo) * B_W'(GAIN_INV);

  assign rest = REST_W'({a[7:0], {GAIN_SPLIT{1'b0}}}) + REST_W'(b);

  always_comb begin
    dst_next   = mid;
    dst_next.x = $signed(DATA_W'(a[A_W-1:8]) + DATA_W'(rest[REST_W-1:32]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      dst_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= src_valid;
      dst_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a   <= a_next;
      b   <= b_next;
      mid <= src;
      dst <= dst_next;
    end
  end

endmodule

>>> hdl/cartesian_to_polar_3d_unit.sv
// Top level of the cartesian to spherical conversion unit.
//
// Converts one signed point (x, y, z), units of 1/16 m, into longitude
// atan2(y, x) and latitude in units of pi/2^31 plus the truncated radius in
// 1/16 m. One point can be taken every cycle while the skid is empty. Between a
// point and its result lie an input register, the two chains of CORDIC cells,
// one register per micro-rotation, two two-stage gain multipliers and the
// result register. The result side has a one-entry skid buffer: a result that
// is not taken is parked there, and the whole pipeline, point_ready included,
// holds while the skid is full. The cycle that parks a result still takes a
// point, but the skid stays full until the result is taken, so an output stall
// holds the input until the parked result is taken. The whole pipeline advances
// together whenever the skid is empty. Origin of the x-y plane reports
// longitude 0, latitude +pi/2 (or -pi/2 for negative z) and radius |z|.
module cartesian_to_polar_3d_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_ready,
  input  c2p3_pkg::point_t  point,
  output logic              result_valid,
  input  logic              result_ready,
  output c2p3_pkg::result_t result
);
  import c2p3_pkg::*;

  // pipeline-wide advance; frozen only while the skid holds a result
  logic adv;

  // input register
  logic                     s0_valid;
  cordic_t                  s0, s0_next;
  logic signed [DATA_W-1:0] xe, ye;
  logic                     x_neg;

  // pass one, gain one, pass two, gain two
  logic    p1_valid, g1_valid, g2_valid, p2_valid;
  cordic_t p1, g1, p2_src, p2, g2;

  // result register and skid
  logic                     fin_valid, skid_valid;
  result_t                  fin, fin_next, skid;
  logic signed [ANGLE_W-1:0] lat_raw;
  logic [DATA_W-GUARD_BITS-1:0] rad_w;
  logic [COORD_W:0]         zw, zabs;

  assign adv         = !skid_valid;
  assign point_ready = adv;

  // fold the left half-plane onto the right with a starting angle of pi
  assign x_neg = point.x_coord < 0;
  assign xe    = DATA_W'(point.x_coord);
  assign ye    = DATA_W'(point.y_coord);

  always_comb begin
    s0_next.x           = (x_neg ? -xe : xe) <<< GUARD_BITS;
    s0_next.y           = (x_neg ? -ye : ye) <<< GUARD_BITS;
    s0_next.angle       = x_neg ? ANGLE_PI : '0;
    s0_next.side.origin = (point.x_coord == 0) && (point.y_coord == 0);
    s0_next.side.z      = point.z_coord;
    s0_next.side.lon    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= s0_next;
    end
  end

  c2p3_cordic_pass u_pass_lon (
    .clk (clk), .rst (rst), .en (adv),
    .src_valid (s0_valid), .src (s0),
    .dst_valid (p1_valid), .dst (p1)
  );

  c2p3_gain_comp u_gain_plane (
    .clk (clk), .rst (rst), .en (adv),
    .src_valid (p1_valid), .src (p1),
    .dst_valid (g1_valid), .dst (g1)
  );

  // second pass rotates (planar magnitude, z); longitude rides along
  always_comb begin
    p2_src          = g1;
    p2_src.y        = DATA_W'(g1.side.z) <<< GUARD_BITS;
    p2_src.angle    = '0;
    p2_src.side.lon = g1.angle;
  end

  c2p3_cordic_pass u_pass_lat (
    .clk (clk), .rst (rst), .en (adv),
    .src_valid (g1_valid), .src (p2_src),
    .dst_valid (p2_valid), .dst (p2)
  );

  c2p3_gain_comp u_gain_space (
    .clk (clk), .rst (rst), .en (adv),
    .src_valid (p2_valid), .src (p2),
    .dst_valid (g2_valid), .dst (g2)
  );

  // clamp latitude, drop guard bits, saturate radius, patch the origin
  assign lat_raw = $signed(g2.angle);
  assign rad_w   = g2.x[DATA_W-1:GUARD_BITS];
  assign zw      = (COORD_W+1)'(g2.side.z);
  assign zabs    = g2.side.z < 0 ? -zw : zw;

  always_comb begin
    fin_next.lon_angle = $signed(g2.side.lon);
    if (lat_raw > LAT_LIMIT) begin
      fin_next.lat_angle = LAT_LIMIT;
    end else if (lat_raw < -LAT_LIMIT) begin
      fin_next.lat_angle = -LAT_LIMIT;
    end else begin
      fin_next.lat_angle = lat_raw;
    end
    if (|rad_w[DATA_W-GUARD_BITS-1:32]) begin
      fin_next.radius = '1;
    end else begin
      fin_next.radius = rad_w[31:0];
    end
    if (g2.side.origin) begin
      fin_next.lon_angle = '0;
      fin_next.lat_angle = (g2.side.z < 0) ? -LAT_LIMIT : LAT_LIMIT;
      fin_next.radius    = zabs[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (adv) begin
        fin_valid <= g2_valid;
        // result shown but not taken: park it before it is overwritten
        if (fin_valid && !result_ready) begin
          skid_valid <= 1'b1;
        end
      end else if (result_ready) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin <= fin_next;
      if (fin_valid && !result_ready) begin
        skid <= fin;
      end
    end
  end

  // skid always holds the older transaction
  assign result_valid = skid_valid || fin_valid;
  assign result       = skid_valid ? skid : fin;

  // skid fills only from a shown, stalled result register
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(fin_valid && !result_ready))
    else $error("skid filled without a stalled result");

  // a parked result freezes the pipeline behind it
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(fin_valid) && $stable(fin))
    else $error("result register moved while skid was full");

  // latitude stays within plus or minus pi/2
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.lat_angle <= LAT_LIMIT) && (result.lat_angle >= -LAT_LIMIT))
    else $error("latitude out of range");

endmodule
